// File: design/app_pkg.sv
// alarm panel poll responder: shared types and constants
// no dependencies; used by the front, queue, back and top level

package app_pkg;

    // frame bytes
    localparam logic [7:0] FRAME_HEAD  = 8'hFC;
    localparam logic [7:0] REPLY_CMD   = 8'h50;
    localparam logic [7:0] SEL_PARTIAL = 8'hFD;
    localparam logic [7:0] SEL_DISARM  = 8'hFE;
    localparam logic [7:0] SEL_ARM     = 8'hFF;

    // item command codes
    localparam logic CMD_RX    = 1'b0;
    localparam logic CMD_LOCAL = 1'b1;

    // panel status codes
    localparam logic [1:0] STAT_ARMED    = 2'd0;
    localparam logic [1:0] STAT_DISARMED = 2'd1;
    localparam logic [1:0] STAT_CANCEL   = 2'd2;
    localparam logic [1:0] STAT_PARTIAL  = 2'd3;

    // event queue depth between front and back
    localparam int EVQ_DEPTH = 2;

    // one event handed from front to back
    typedef struct packed {
        logic       is_local;   // local status request, else good frame
        logic [1:0] status;     // requested status for a local request
        logic       cmd_zero;   // frame command byte was zero
        logic [7:0] id;         // frame id byte
        logic [7:0] len;        // frame payload length
    } t_event;

    // hold conditions the front sees from the rest of the block
    typedef struct packed {
        logic q_full;       // event queue cannot take another event
        logic commit_busy;  // staged payload not yet copied out
    } t_front_hold;

endpackage

// File: design/app_if.sv
// stream interfaces for the input and result channels
// no dependencies

interface app_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;
    logic [1:0] new_status;

    modport source (output valid, output command, output rx_byte, output new_status,
                    input ready);
    modport sink   (input valid, input command, input rx_byte, input new_status,
                    output ready);
endinterface

interface app_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_byte;
    logic [1:0] panel_status;

    modport source (output valid, output tx_byte, output last_byte, output panel_status,
                    input ready);
    modport sink   (input valid, input tx_byte, input last_byte, input panel_status,
                    output ready);
endinterface

// File: design/app_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies

module app_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/app_front.sv
// deframer: hunts for the header, checks length and checksum, stages payload
// depends on app_pkg and app_in_if; writes the staging ram, pushes events

module app_front import app_pkg::*; #(
    parameter int MAX_FRAME_LEN = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    app_in_if.sink                           i_in,
    input  t_front_hold                      i_hold,
    output logic                             o_ev_push,
    output t_event                           o_ev,
    output logic                             o_stg_we,
    output logic [$clog2(MAX_FRAME_LEN)-1:0] o_stg_waddr,
    output logic [7:0]                       o_stg_wdata
);

    localparam int LW = $clog2(MAX_FRAME_LEN);
    localparam int SW = $clog2(MAX_FRAME_LEN + 2);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    logic [1:0]    r_phase, n_phase;
    logic [LW-1:0] r_len, n_len;
    logic [SW-1:0] r_seen, n_seen;
    logic [7:0]    r_xor, n_xor;
    logic [7:0]    r_cmd, n_cmd;
    logic [7:0]    r_id, n_id;

    logic          w_ready;
    logic          w_accept;
    logic [SW-1:0] w_end;
    logic          w_in_payload;
    logic [7:0]    w_xor;

    // payload window of the current frame
    assign w_end        = SW'(r_len) + SW'(2);
    assign w_in_payload = (r_phase == PH_BODY) && (r_seen >= SW'(2)) && (r_seen < w_end);
    assign w_xor        = r_xor ^ i_in.rx_byte;

    // payload bytes wait while the staging ram still holds an uncopied frame
    assign w_ready    = !i_hold.q_full && !(w_in_payload && i_hold.commit_busy);
    assign w_accept   = i_in.valid && w_ready;
    assign i_in.ready = w_ready;

    // staging ram write
    assign o_stg_we    = w_accept && (i_in.command == CMD_RX) && w_in_payload;
    assign o_stg_waddr = LW'(r_seen - SW'(2));
    assign o_stg_wdata = i_in.rx_byte;

    // deframing state machine and event generation
    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_seen    = r_seen;
        n_xor     = r_xor;
        n_cmd     = r_cmd;
        n_id      = r_id;
        o_ev_push = 1'b0;
        o_ev      = '{is_local: 1'b0, status: i_in.new_status, cmd_zero: (r_cmd == 8'h00),
                      id: r_id, len: 8'(r_len)};
        if (w_accept) begin
            if (i_in.command == CMD_LOCAL) begin
                o_ev.is_local = 1'b1;
                o_ev_push     = (i_in.new_status != STAT_PARTIAL);
            end else begin
                unique case (r_phase)
                    PH_HUNT: begin
                        if (i_in.rx_byte == FRAME_HEAD) begin
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (int'(i_in.rx_byte) < MAX_FRAME_LEN) begin
                            n_len   = LW'(i_in.rx_byte);
                            n_xor   = i_in.rx_byte;
                            n_seen  = '0;
                            n_phase = PH_BODY;
                        end else begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_BODY: begin
                        n_xor = w_xor;
                        if (r_seen == SW'(0)) begin
                            n_cmd = i_in.rx_byte;
                        end else if (r_seen == SW'(1)) begin
                            n_id = i_in.rx_byte;
                        end
                        if (r_seen >= w_end) begin
                            n_phase   = PH_HUNT;
                            n_seen    = '0;
                            o_ev_push = (w_xor == 8'h00);
                        end else begin
                            n_seen = r_seen + SW'(1);
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_seen  <= '0;
            r_xor   <= '0;
            r_cmd   <= '0;
            r_id    <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_xor   <= n_xor;
            r_cmd   <= n_cmd;
            r_id    <= n_id;
        end
    end

endmodule

// File: design/app_evq.sv
// short event queue between the deframer and the responder
// depends on app_pkg

module app_evq import app_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_ev,
    input  logic   i_pop,
    output t_event o_ev,
    output logic   o_empty,
    output logic   o_full
);

    localparam int PTR_W = $clog2(EVQ_DEPTH);
    localparam int CNT_W = $clog2(EVQ_DEPTH + 1);

    t_event             r_mem [EVQ_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_cnt;

    assign o_empty = (r_cnt == CNT_W'(0));
    assign o_full  = (r_cnt == CNT_W'(EVQ_DEPTH));
    assign o_ev    = r_mem[r_rptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_ev;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// File: design/app_back.sv
// responder: commits staged payload, runs the status and poll logic, sends replies
// depends on app_pkg, app_out_if and app_ram (payload store)

module app_back import app_pkg::*; #(
    parameter int MAX_FRAME_LEN = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_ev_vld,
    input  t_event                           i_ev,
    output logic                             o_ev_pop,
    output logic [$clog2(MAX_FRAME_LEN)-1:0] o_stg_raddr,
    input  logic [7:0]                       i_stg_rdata,
    output logic                             o_busy,
    app_out_if.source                        o_out
);

    localparam int LW = $clog2(MAX_FRAME_LEN);
    localparam int PW = $clog2(MAX_FRAME_LEN + 5);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_COPY   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_SEND   = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic [7:0]    r_id, n_id;
    logic          r_cmd0, n_cmd0;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_x, n_x;
    logic [7:0]    r_p0, n_p0;
    logic [1:0]    r_status, n_status;
    logic          r_first, n_first;
    logic          r_sync, n_sync;
    logic [7:0]    r_last_id, n_last_id;
    logic [7:0]    r_upload, n_upload;
    logic          r_o_vld, n_o_vld;
    logic [7:0]    r_o_byte, n_o_byte;
    logic          r_o_last, n_o_last;
    logic [1:0]    r_o_stat, n_o_stat;

    logic          w_st_we;
    logic [LW-1:0] w_st_waddr;
    logic [LW-1:0] w_st_raddr;
    logic [7:0]    w_st_rdata;
    logic          w_load;
    logic [PW-1:0] w_chk_pos;
    logic [7:0]    w_byte;
    logic          w_reply;

    // payload store, entry 0 also mirrored in r_p0
    app_ram #(.WIDTH(8), .DEPTH(MAX_FRAME_LEN)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_waddr),
        .i_wdata (i_stg_rdata),
        .i_raddr (w_st_raddr),
        .o_rdata (w_st_rdata)
    );

    assign o_busy      = (r_state == S_COPY);
    assign o_ev_pop    = (r_state == S_IDLE) && i_ev_vld;
    assign o_stg_raddr = r_cnt;

    // each copy write stores the staging byte read in the cycle before
    assign w_st_we    = (r_state == S_COPY) && (r_cnt != LW'(0));
    assign w_st_waddr = r_cnt - LW'(1);

    // reply byte at the current position
    assign w_load    = !r_o_vld || o_out.ready;
    assign w_chk_pos = PW'(r_len) + PW'(4);
    always_comb begin
        if (r_pos == PW'(0)) begin
            w_byte = FRAME_HEAD;
        end else if (r_pos == PW'(1)) begin
            w_byte = 8'(r_len);
        end else if (r_pos == PW'(2)) begin
            w_byte = REPLY_CMD;
        end else if (r_pos == PW'(3)) begin
            w_byte = r_id;
        end else if (r_pos == w_chk_pos) begin
            w_byte = r_x;
        end else if (r_pos == PW'(4)) begin
            w_byte = r_p0;
        end else begin
            w_byte = w_st_rdata;
        end
    end

    // store read address runs one position ahead of the byte being sent
    assign w_st_raddr = LW'(n_pos - PW'(4));

    // responder sequencer
    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_id      = r_id;
        n_cmd0    = r_cmd0;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_x       = r_x;
        n_p0      = r_p0;
        n_status  = r_status;
        n_first   = r_first;
        n_sync    = r_sync;
        n_last_id = r_last_id;
        n_upload  = r_upload;
        n_o_vld   = r_o_vld && !o_out.ready;
        n_o_byte  = r_o_byte;
        n_o_last  = r_o_last;
        n_o_stat  = r_o_stat;
        w_reply   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_ev_vld) begin
                    if (i_ev.is_local) begin
                        n_status = i_ev.status;
                        n_sync   = 1'b1;
                    end else begin
                        n_len  = LW'(i_ev.len);
                        n_id   = i_ev.id;
                        n_cmd0 = i_ev.cmd_zero;
                        n_cnt  = '0;
                        n_state = (i_ev.len == 8'h00) ? S_DECIDE : S_COPY;
                    end
                end
            end
            S_COPY: begin
                if (r_cnt == LW'(1)) begin
                    n_p0 = i_stg_rdata;
                end
                if (r_cnt == r_len) begin
                    n_state = S_DECIDE;
                end else begin
                    n_cnt = r_cnt + LW'(1);
                end
            end
            S_DECIDE: begin
                if (r_cmd0) begin
                    if (r_p0[7:2] == 6'd0) begin
                        // direct status set
                        n_status = r_p0[1:0];
                        n_p0     = SEL_ARM;
                        w_reply  = 1'b1;
                    end else if (r_p0 >= SEL_PARTIAL) begin
                        if (r_first) begin
                            // first-start sync
                            n_status = (r_p0 == SEL_PARTIAL) ? STAT_PARTIAL :
                                       (r_p0 == SEL_DISARM)  ? STAT_DISARMED : STAT_ARMED;
                            n_first  = 1'b0;
                            n_p0     = SEL_ARM;
                            w_reply  = 1'b1;
                        end else if (r_last_id == r_id) begin
                            // repeated poll: retransmit pending upload only
                            if (r_last_id == r_upload) begin
                                n_p0    = {6'd0, r_status};
                                w_reply = 1'b1;
                            end
                        end else begin
                            n_last_id = r_id;
                            w_reply   = 1'b1;
                            if (r_sync && (r_id != 8'h00)) begin
                                // upload the locally changed status
                                n_p0     = {6'd0, r_status};
                                n_sync   = 1'b0;
                                n_upload = r_id;
                            end else begin
                                if (r_status == STAT_CANCEL) begin
                                    n_status = (r_p0 == SEL_PARTIAL) ? STAT_PARTIAL :
                                               (r_p0 == SEL_DISARM)  ? STAT_DISARMED :
                                                                       STAT_ARMED;
                                end
                                n_upload = 8'h00;
                                n_p0     = SEL_ARM;
                            end
                        end
                    end
                end
                n_pos   = '0;
                n_x     = '0;
                n_state = w_reply ? S_SEND : S_IDLE;
            end
            S_SEND: begin
                if (w_load) begin
                    n_o_vld  = 1'b1;
                    n_o_byte = w_byte;
                    n_o_last = (r_pos == w_chk_pos);
                    n_o_stat = r_status;
                    n_pos    = r_pos + PW'(1);
                    if (r_pos != PW'(0)) begin
                        n_x = r_x ^ w_byte;
                    end
                    if (r_pos == w_chk_pos) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and status registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_id      <= '0;
            r_cmd0    <= 1'b0;
            r_cnt     <= '0;
            r_pos     <= '0;
            r_x       <= '0;
            r_p0      <= '0;
            r_status  <= STAT_ARMED;
            r_first   <= 1'b1;
            r_sync    <= 1'b0;
            r_last_id <= '0;
            r_upload  <= '0;
            r_o_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_id      <= n_id;
            r_cmd0    <= n_cmd0;
            r_cnt     <= n_cnt;
            r_pos     <= n_pos;
            r_x       <= n_x;
            r_p0      <= n_p0;
            r_status  <= n_status;
            r_first   <= n_first;
            r_sync    <= n_sync;
            r_last_id <= n_last_id;
            r_upload  <= n_upload;
            r_o_vld   <= n_o_vld;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        r_o_byte <= n_o_byte;
        r_o_last <= n_o_last;
        r_o_stat <= n_o_stat;
    end

    assign o_out.valid        = r_o_vld;
    assign o_out.tx_byte      = r_o_byte;
    assign o_out.last_byte    = r_o_last;
    assign o_out.panel_status = r_o_stat;

endmodule

// File: design/alarm_panel_poll_responder.sv
// channel   direction  payload
// i_in      sink       command, rx_byte, new_status
// o_out     source     tx_byte, last_byte, panel_status
//
// a good frame is queued; the responder then pops it, copies the staged payload (no copy
// when L is 0), decides, and if a reply is due sends its L+5 bytes, one byte per cycle
// while the output is not stalled
// the deframer keeps taking bytes meanwhile; only items in the payload window of the next
// frame wait while an event is queued or the staging ram copy runs, and any item waits while the
// queue is full
// a stalled result holds in the output register and stalls the responder
// reset is synchronous and active low; no clearing pass is needed
// top level: deframer, event queue, responder and staging ram
// depends on app_pkg, app_if, app_ram, app_front, app_evq and app_back

module alarm_panel_poll_responder import app_pkg::*; #(
    parameter int MAX_FRAME_LEN = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    app_in_if.sink    i_in,
    app_out_if.source o_out
);

    localparam int LW = $clog2(MAX_FRAME_LEN);

    t_front_hold   w_hold;
    logic          w_push;
    t_event        w_push_ev;
    t_event        w_pop_ev;
    logic          w_pop;
    logic          w_empty;
    logic          w_full;
    logic          w_busy;
    logic          w_stg_we;
    logic [LW-1:0] w_stg_waddr;
    logic [7:0]    w_stg_wdata;
    logic [LW-1:0] w_stg_raddr;
    logic [7:0]    w_stg_rdata;

    assign w_hold = '{q_full: w_full, commit_busy: (!w_empty || w_busy)};

    // deframer
    app_front #(.MAX_FRAME_LEN(MAX_FRAME_LEN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_hold      (w_hold),
        .o_ev_push   (w_push),
        .o_ev        (w_push_ev),
        .o_stg_we    (w_stg_we),
        .o_stg_waddr (w_stg_waddr),
        .o_stg_wdata (w_stg_wdata)
    );

    // staged payload of the frame being received
    app_ram #(.WIDTH(8), .DEPTH(MAX_FRAME_LEN)) u_stage (
        .i_clk   (i_clk),
        .i_we    (w_stg_we),
        .i_waddr (w_stg_waddr),
        .i_wdata (w_stg_wdata),
        .i_raddr (w_stg_raddr),
        .o_rdata (w_stg_rdata)
    );

    // event queue
    app_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ev    (w_push_ev),
        .i_pop   (w_pop),
        .o_ev    (w_pop_ev),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // responder
    app_back #(.MAX_FRAME_LEN(MAX_FRAME_LEN)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ev_vld    (!w_empty),
        .i_ev        (w_pop_ev),
        .o_ev_pop    (w_pop),
        .o_stg_raddr (w_stg_raddr),
        .i_stg_rdata (w_stg_rdata),
        .o_busy      (w_busy),
        .o_out       (o_out)
    );

endmodule

// File: design/app_checker.sv
// port level checks on the reply channel of the poll responder
// depends on app_pkg; bound to alarm_panel_poll_responder

module app_checker import app_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_tx_byte,
    input logic       i_last_byte,
    input logic [1:0] i_panel_status
);

    // reset leaves no reply pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("reply item valid right after reset");

    // a stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_tx_byte))
        else $error("reply item dropped or changed while stalled");

    // reply bytes follow back to back until the checksum byte
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_byte |=> i_out_valid)
        else $error("gap inside a reply");

    // status is the same on every byte of one reply
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_byte |=>
        i_panel_status == $past(i_panel_status))
        else $error("panel status changed inside a reply");

endmodule

bind alarm_panel_poll_responder app_checker u_app_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_tx_byte      (o_out.tx_byte),
    .i_last_byte    (o_out.last_byte),
    .i_panel_status (o_out.panel_status)
);

// File: verif/testbench.sv
// testbench for alarm_panel_poll_responder: deframes random and directed byte streams
// and checks every reply byte against an internal prediction of the panel
// depends on app_pkg, app_if and the alarm_panel_poll_responder rtl

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import app_pkg::*;

    localparam int         MAX_LEN      = 8;
    localparam logic [7:0] OVERSIZE_LEN = 8'(MAX_LEN);
    localparam logic [7:0] ACK_BYTE     = 8'hFF;
    localparam int         SETTLE       = 64;
    localparam int         DRAIN_LIMIT  = 4000;
    localparam int         HOLD_AT      = 120;
    localparam int         HOLD_LEN     = 400;
    localparam int         PRINT_CAP    = 20;

    typedef enum logic [1:0] {SEEK_HEAD, SEEK_LEN, IN_BODY} t_parse_phase;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic [1:0] new_status;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic [1:0] stat;
    } t_reply_byte;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    app_in_if  in_if();
    app_out_if out_if();

    alarm_panel_poll_responder #(.MAX_FRAME_LEN(MAX_LEN)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // stimulus side signals, known from time zero
    logic       drv_valid  = 1'b0;
    logic       drv_cmd    = CMD_RX;
    logic [7:0] drv_byte   = 8'd0;
    logic [1:0] drv_status = STAT_ARMED;
    logic       rcv_ready  = 1'b0;

    assign in_if.valid      = drv_valid;
    assign in_if.command    = drv_cmd;
    assign in_if.rx_byte    = drv_byte;
    assign in_if.new_status = drv_status;
    assign out_if.ready     = rcv_ready;

    // clock, period 2 ns
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predicted panel state
    t_parse_phase parse_st;
    logic [2:0]   flen;
    logic [3:0]   nseen;
    logic [7:0]   xsum;
    logic [7:0]   fcmd;
    logic [7:0]   fid;
    logic [7:0]   pay_mem   [MAX_LEN];
    logic [7:0]   stage_mem [MAX_LEN];
    logic [1:0]   stat;
    logic         first_boot;
    logic         sync_due;
    logic [7:0]   poll_id_last;
    logic [7:0]   upload_tag;

    t_reply_byte reply_q[$];
    t_in_item    send_q[$];

    int unsigned pushed      = 0;
    int unsigned errors      = 0;
    int unsigned items_taken = 0;
    logic        in_took     = 1'b0;
    t_reply_byte exp_byte;

    task automatic clear_panel_model();
        int i;
        parse_st     = SEEK_HEAD;
        flen         = 3'd0;
        nseen        = 4'd0;
        xsum         = 8'd0;
        fcmd         = 8'd0;
        fid          = 8'd0;
        for (i = 0; i < MAX_LEN; i++) begin
            pay_mem[i]   = 8'd0;
            stage_mem[i] = 8'd0;
        end
        stat         = STAT_ARMED;
        first_boot   = 1'b1;
        sync_due     = 1'b0;
        poll_id_last = 8'd0;
        upload_tag   = 8'd0;
    endtask

    // id based poll: retransmit, pending sync upload, or plain ack
    function automatic logic answer_poll();
        if (poll_id_last == fid) begin
            if (poll_id_last == upload_tag) begin
                pay_mem[0] = {6'd0, stat};
                return 1'b1;
            end
            return 1'b0;
        end
        poll_id_last = fid;
        if (sync_due && fid != 8'd0) begin
            pay_mem[0] = {6'd0, stat};
            sync_due   = 1'b0;
            upload_tag = fid;
            return 1'b1;
        end
        if (stat == STAT_CANCEL) begin
            if (pay_mem[0] == SEL_PARTIAL)
                stat = STAT_PARTIAL;
            else if (pay_mem[0] == SEL_DISARM)
                stat = STAT_DISARMED;
            else if (pay_mem[0] == SEL_ARM)
                stat = STAT_ARMED;
        end
        upload_tag = 8'd0;
        pay_mem[0] = ACK_BYTE;
        return 1'b1;
    endfunction

    // what a good frame does; returns whether a reply goes out
    function automatic logic decide_frame();
        logic [7:0] sel;
        sel = pay_mem[0];
        if (fcmd != 8'd0)
            return 1'b0;
        if (sel <= {6'd0, STAT_PARTIAL}) begin
            stat       = sel[1:0];
            pay_mem[0] = ACK_BYTE;
            return 1'b1;
        end
        if (sel >= SEL_PARTIAL) begin
            if (first_boot) begin
                if (sel == SEL_PARTIAL)
                    stat = STAT_PARTIAL;
                else if (sel == SEL_DISARM)
                    stat = STAT_DISARMED;
                else
                    stat = STAT_ARMED;
                first_boot = 1'b0;
                pay_mem[0] = ACK_BYTE;
                return 1'b1;
            end
            return answer_poll();
        end
        return 1'b0;
    endfunction

    task automatic push_reply_byte(input logic [7:0] d, input logic fin);
        t_reply_byte rb;
        rb.data = d;
        rb.fin  = fin;
        rb.stat = stat;
        reply_q.push_back(rb);
    endtask

    // advance the deframer by one accepted item and queue the expected reply
    task automatic predict_input(input logic cmd, input logic [7:0] b, input logic [1:0] ns);
        logic       send;
        logic [7:0] chk;
        logic [3:0] body_end;
        int         i;
        send = 1'b0;
        if (cmd == CMD_LOCAL) begin
            if (ns != STAT_PARTIAL) begin
                stat     = ns;
                sync_due = 1'b1;
            end
        end else begin
            case (parse_st)
                SEEK_HEAD: begin
                    if (b == FRAME_HEAD)
                        parse_st = SEEK_LEN;
                end
                SEEK_LEN: begin
                    if (b < OVERSIZE_LEN) begin
                        flen     = b[2:0];
                        xsum     = b;
                        nseen    = 4'd0;
                        parse_st = IN_BODY;
                    end else begin
                        parse_st = SEEK_HEAD;
                    end
                end
                default: begin
                    body_end = {1'b0, flen} + 4'd2;
                    xsum     = xsum ^ b;
                    if (nseen == 4'd0)
                        fcmd = b;
                    else if (nseen == 4'd1)
                        fid = b;
                    else if (nseen < body_end)
                        stage_mem[3'(nseen - 4'd2)] = b;
                    if (nseen >= body_end) begin
                        parse_st = SEEK_HEAD;
                        nseen    = 4'd0;
                        if (xsum == 8'd0) begin
                            for (i = 0; i < flen; i++)
                                pay_mem[i] = stage_mem[i];
                            send = decide_frame();
                        end
                    end else begin
                        nseen = nseen + 4'd1;
                    end
                end
            endcase
        end
        // reply: header, length, reply command, id, payload, checksum
        if (send) begin
            chk = {5'd0, flen} ^ REPLY_CMD ^ fid;
            push_reply_byte(FRAME_HEAD, 1'b0);
            push_reply_byte({5'd0, flen}, 1'b0);
            push_reply_byte(REPLY_CMD, 1'b0);
            push_reply_byte(fid, 1'b0);
            for (i = 0; i < flen; i++) begin
                chk = chk ^ pay_mem[i];
                push_reply_byte(pay_mem[i], 1'b0);
            end
            push_reply_byte(chk, 1'b1);
        end
    endtask

    // stimulus builders
    task automatic push_item(input logic cmd, input logic [7:0] b, input logic [1:0] ns);
        t_in_item it;
        it.command    = cmd;
        it.rx_byte    = b;
        it.new_status = ns;
        send_q.push_back(it);
        pushed++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(CMD_RX, b, 2'($urandom_range(0, 3)));
    endtask

    task automatic push_local(input logic [1:0] ns);
        push_item(CMD_LOCAL, 8'($urandom_range(0, 255)), ns);
    endtask

    task automatic push_frame(input logic [7:0] len, input logic [7:0] cmd,
                              input logic [7:0] id, input logic [7:0] first,
                              input logic corrupt);
        logic [7:0] chk;
        logic [7:0] pb;
        int         k;
        push_byte(FRAME_HEAD);
        push_byte(len);
        push_byte(cmd);
        push_byte(id);
        chk = len ^ cmd ^ id;
        for (k = 0; k < len; k++) begin
            pb  = (k == 0) ? first : 8'($urandom_range(0, 255));
            chk = chk ^ pb;
            push_byte(pb);
        end
        if (corrupt)
            chk = chk ^ (8'd1 << $urandom_range(0, 7));
        push_byte(chk);
    endtask

    // mostly good frames with random content, the rest local requests, noise and broken frames
    task automatic push_random_traffic(input int unsigned target);
        int unsigned r;
        int unsigned pick;
        logic [7:0]  len;
        logic [7:0]  cmd;
        logic [7:0]  id;
        logic [7:0]  first;
        while (pushed < target) begin
            r   = $urandom_range(0, 99);
            len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(4, 7))
                                              : 8'($urandom_range(0, 3));
            cmd = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
            id  = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 3));
            pick = $urandom_range(0, 9);
            if (pick < 3)
                first = 8'($urandom_range(0, 3));
            else if (pick < 8)
                first = 8'($urandom_range(SEL_PARTIAL, SEL_ARM));
            else
                first = 8'($urandom_range(0, 255));
            if (r < 70)
                push_frame(len, cmd, id, first, 1'b0);
            else if (r < 80)
                push_frame(len, cmd, id, first, 1'b1);
            else if (r < 90)
                push_local(2'($urandom_range(0, 3)));
            else if (r < 95)
                push_byte(8'($urandom_range(0, 255)));
            else begin
                push_byte(FRAME_HEAD);
                push_byte(8'($urandom_range(MAX_LEN, 255)));
            end
        end
    endtask

    // hold the sender until all items are taken and every reply byte has come or the drain limit is hit
    task automatic wait_quiet();
        int n;
        while (send_q.size() != 0 || drv_valid)
            @(posedge i_clk);
        n = 0;
        while (reply_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // driver: bursts of items with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    t_in_item    drv_item;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else if (drv_valid && !in_took) begin
            // item still offered, waiting for ready
        end else if (burst_left != 0 && send_q.size() != 0) begin
            drv_item = send_q.pop_front();
            drv_valid  <= 1'b1;
            drv_cmd    <= drv_item.command;
            drv_byte   <= drv_item.rx_byte;
            drv_status <= drv_item.new_status;
            burst_left <= burst_left - 1;
        end else begin
            drv_valid <= 1'b0;
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
            end else begin
                burst_left <= ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
                gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(6, 20)
                                                          : $urandom_range(0, 3);
            end
        end
    end

    // receiver: rotating stall pattern plus one long hold-off
    logic [31:0] rx_cycle  = 32'd0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rcv_ready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 32'd1;
            if (hold_left != 0) begin
                rcv_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && items_taken >= HOLD_AT) begin
                rcv_ready <= 1'b0;
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN;
            end else begin
                case (rx_cycle[7:6])
                    2'd0: rcv_ready <= 1'b1;
                    2'd1: rcv_ready <= ($urandom_range(0, 3) != 0);
                    2'd2: rcv_ready <= 1'($urandom_range(0, 1));
                    default: rcv_ready <= (rx_cycle % 3 != 0);
                endcase
            end
        end
    end

    // monitor: check reply bytes, predict on accepted items
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (reply_q.size() == 0) begin
                if (errors < PRINT_CAP)
                    $display("%0t ns: unexpected reply byte: expected none, got %02h/%b/%0d",
                             $time, out_if.tx_byte, out_if.last_byte, out_if.panel_status);
                errors <= errors + 1;
            end else begin
                exp_byte = reply_q.pop_front();
                if (out_if.tx_byte !== exp_byte.data || out_if.last_byte !== exp_byte.fin ||
                    out_if.panel_status !== exp_byte.stat) begin
                    if (errors < PRINT_CAP)
                        $display("%0t ns: reply byte mismatch: expected %02h/%b/%0d, got %02h/%b/%0d",
                                 $time, exp_byte.data, exp_byte.fin, exp_byte.stat,
                                 out_if.tx_byte, out_if.last_byte, out_if.panel_status);
                    errors <= errors + 1;
                end
            end
        end
        if (i_rst_n && in_if.valid && in_if.ready) begin
            predict_input(in_if.command, in_if.rx_byte, in_if.new_status);
            items_taken <= items_taken + 1;
        end
        in_took <= i_rst_n && in_if.valid && in_if.ready;
    end

    // stimulus sequence and verdict
    initial begin
        clear_panel_model();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // oversize length, dropped and back to hunting
        push_byte(FRAME_HEAD);
        push_byte(OVERSIZE_LEN);
        // direct status set to cancel
        push_frame(8'd1, 8'd0, 8'd0, {6'd0, STAT_CANCEL}, 1'b0);
        // empty payload reuses the stored ack byte: first-start sync
        push_frame(8'd0, 8'd0, 8'd5, 8'd0, 1'b0);
        // bad checksum
        push_frame(8'd0, 8'h01, 8'd5, 8'd0, 1'b1);
        // local requests, status 3 ignored
        push_local(STAT_PARTIAL);
        push_local(STAT_CANCEL);
        // poll with sync pending uploads the status
        push_frame(8'd0, 8'd0, 8'd7, 8'd0, 1'b0);
        // nonzero command and unknown selector give no reply
        push_frame(8'd0, 8'hFF, 8'd7, 8'd0, 1'b0);
        push_frame(8'd1, 8'd0, 8'd9, FRAME_HEAD, 1'b0);
        wait_quiet();

        push_random_traffic(160);
        wait_quiet();
        push_random_traffic(310);
        wait_quiet();

        if (reply_q.size() != 0)
            $display("%0t ns: %0d reply bytes never arrived", $time, reply_q.size());
        if (errors == 0 && reply_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run limit
    initial begin
        #400000;
        $display("%0t ns: run limit reached", $time);
        $display("Some tests failed");
        $finish;
    end

endmodule
